// ===== hdl/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Shared constants, register indexes and the command and status structures
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pid_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int TIME_FRAC_BITS  = 20;
   localparam int ZERO_STEP_UNITS = 1049;
   localparam int MUL_DIGIT       = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_LOW     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_HIGH    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEGRAL_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET         = 3'd6;

   localparam longint GAIN_P_RESET         = 65536;
   localparam longint GAIN_I_RESET         = 0;
   localparam longint GAIN_D_RESET         = 0;
   localparam longint OUTPUT_LOW_RESET     = -6553600;
   localparam longint OUTPUT_HIGH_RESET    = 6553600;
   localparam longint INTEGRAL_LIMIT_RESET = 6553600;
   localparam longint TARGET_RESET         = 0;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   typedef logic [1:0] mul_op_type;
   localparam mul_op_type MUL_INC = 2'd0;
   localparam mul_op_type MUL_P   = 2'd1;
   localparam mul_op_type MUL_I   = 2'd2;
   localparam mul_op_type MUL_D   = 2'd3;

   typedef struct packed {
      logic       load_in;
      logic       clear_state;
      logic       calc_error;
      logic       start_div;
      logic       save_error;
      logic       mul_start;
      mul_op_type mul_op;
      logic       mul_fix;
      logic       integ_update;
      logic       sum_clear;
      logic       sum_add;
      logic       deriv_load;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic div_busy;
   } stat_type;

endpackage

// ===== hdl/pid_mul.sv =====
// ----------------------------------------------------------------------------
// PID sequential multiplier
// Unsigned multiplier that consumes one 16-bit digit of the multiplier per
// cycle and shifts the finished low product bits out to the right.
// ----------------------------------------------------------------------------
module pid_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    mcand,
   input  logic [BW-1:0]    mplier,
   output logic             busy,
   output logic [AW+BW-1:0] product
);

   localparam int D  = pid_pkg::MUL_DIGIT;
   localparam int ND = (BW + D - 1) / D;
   localparam int BP = ND * D;
   localparam int CW = $clog2(ND + 1);

   logic [AW-1:0]      mcand_ff, mcand_in;
   logic [BP-1:0]      mplier_ff, mplier_in;
   logic [AW+BP-1:0]   prod_ff, prod_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW+D-1:0]    pp;
   logic [AW+D-1:0]    part;
   logic [AW+D+BP-1:0] wide;

   always_comb begin
      pp        = {{D{1'b0}}, mcand_ff} * {{AW{1'b0}}, mplier_ff[D-1:0]};
      part      = {{D{1'b0}}, prod_ff[AW+BP-1:BP]} + pp;
      wide      = {part, prod_ff[BP-1:0]};
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         mcand_in  = mcand;
         mplier_in = BP'(mplier);
         prod_in   = '0;
         cnt_in    = CW'(ND);
      end else if (cnt_ff != '0) begin
         mplier_in = mplier_ff >> D;
         prod_in   = wide[AW+D+BP-1:D];
         cnt_in    = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign busy    = (cnt_ff != '0);
   assign product = prod_ff[AW+BW-1:0];

endmodule

// ===== hdl/pid_div.sv =====
// ----------------------------------------------------------------------------
// PID derivative divider
// Restoring divider that forms one quotient bit per cycle of the error
// change scaled by 2^20 over the time step, with an overflow flag.
// ----------------------------------------------------------------------------
module pid_div #(
   parameter int VALUE_WIDTH = 32,
   parameter int STEP_WIDTH  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [STEP_WIDTH-1:0]  divisor,
   output logic                   busy,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic                   overflow
);

   localparam int W  = VALUE_WIDTH;
   localparam int S  = STEP_WIDTH;
   localparam int TF = pid_pkg::TIME_FRAC_BITS;
   localparam int CW = $clog2(W + 1);

   logic [W+TF-1:0] nfull;
   logic [TF-1:0]   r0;
   logic [S:0]      trial;
   logic [S:0]      trial_sub;
   logic            ge;
   logic [S-1:0]    rem_ff, rem_in;
   logic [W-1:0]    nlow_ff, nlow_in;
   logic [W-1:0]    q_ff, q_in;
   logic            ovf_ff, ovf_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      nfull     = {dividend, {TF{1'b0}}};
      r0        = nfull[W+TF-1:W];
      trial     = {rem_ff, nlow_ff[W-1]};
      trial_sub = trial - {1'b0, divisor};
      ge        = (trial >= {1'b0, divisor});
      rem_in    = rem_ff;
      nlow_in   = nlow_ff;
      q_in      = q_ff;
      ovf_in    = ovf_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         rem_in  = S'(r0);
         nlow_in = nfull[W-1:0];
         q_in    = '0;
         ovf_in  = ({{S{1'b0}}, r0} >= {{TF{1'b0}}, divisor});
         cnt_in  = CW'(W);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? trial_sub[S-1:0] : trial[S-1:0];
         nlow_in = nlow_ff << 1;
         q_in    = {q_ff[W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      nlow_ff <= nlow_in;
      q_ff    <= q_in;
      ovf_ff  <= ovf_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = q_ff;
   assign overflow = ovf_ff;

endmodule

// ===== hdl/pid_datapath.sv =====
// ----------------------------------------------------------------------------
// PID datapath
// Configuration registers, kept state, error, integral and derivative
// arithmetic, term accumulation and output clamping.
// ----------------------------------------------------------------------------
module pid_datapath #(
   parameter int VALUE_WIDTH = 32,
   parameter int STEP_WIDTH  = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pid_pkg::cmd_type                     cmd,
   output pid_pkg::stat_type                    stat,
   input  logic                                 csr_we,
   input  logic [pid_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [VALUE_WIDTH-1:0]               csr_wdata,
   input  logic signed [VALUE_WIDTH-1:0]        measured,
   input  logic [STEP_WIDTH-1:0]                step_time,
   output logic signed [VALUE_WIDTH-1:0]        drive
);

   localparam int W  = VALUE_WIDTH;
   localparam int S  = STEP_WIDTH;
   localparam int BW = (W > S) ? W : S;
   localparam int PW = W + BW + 1;
   localparam int SW = W + 2;
   localparam int TF = pid_pkg::TIME_FRAC_BITS;
   localparam int FB = pid_pkg::FRAC_BITS;

   localparam longint VMAX_L = (longint'(1) <<< (W - 1)) - longint'(1);
   localparam longint VMIN_L = -VMAX_L - longint'(1);
   localparam longint LOW_L  = (pid_pkg::OUTPUT_LOW_RESET < VMIN_L) ? VMIN_L :
                               ((pid_pkg::OUTPUT_LOW_RESET > VMAX_L) ? VMAX_L :
                                pid_pkg::OUTPUT_LOW_RESET);
   localparam longint HIGH_L = (pid_pkg::OUTPUT_HIGH_RESET < VMIN_L) ? VMIN_L :
                               ((pid_pkg::OUTPUT_HIGH_RESET > VMAX_L) ? VMAX_L :
                                pid_pkg::OUTPUT_HIGH_RESET);
   localparam longint LIM_L  = (pid_pkg::INTEGRAL_LIMIT_RESET > VMAX_L) ? VMAX_L :
                               pid_pkg::INTEGRAL_LIMIT_RESET;

   localparam logic signed [W-1:0]  VMAX_W = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  VMIN_W = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [PW-1:0] MAX_P  = PW'(VMAX_L);
   localparam logic signed [PW-1:0] MIN_P  = PW'(VMIN_L);
   localparam logic signed [SW-1:0] MAX_S  = SW'(VMAX_L);
   localparam logic signed [SW-1:0] MIN_S  = SW'(VMIN_L);

   logic signed [W-1:0] gain_p_ff, gain_p_in;
   logic signed [W-1:0] gain_i_ff, gain_i_in;
   logic signed [W-1:0] gain_d_ff, gain_d_in;
   logic signed [W-1:0] out_low_ff, out_low_in;
   logic signed [W-1:0] out_high_ff, out_high_in;
   logic [W-2:0]        limit_ff, limit_in;
   logic signed [W-1:0] target_ff, target_in;

   logic signed [W-1:0] meas_ff, meas_in;
   logic [S-1:0]        dt_ff, dt_in;
   logic signed [W-1:0] err_ff, err_in;
   logic signed [W-1:0] last_err_ff, last_err_in;
   logic signed [W-1:0] integ_ff, integ_in;
   logic signed [W-1:0] deriv_ff, deriv_in;
   logic                dneg_ff, dneg_in;
   logic                mneg_ff, mneg_in;
   pid_pkg::mul_op_type mop_ff, mop_in;
   logic signed [PW-1:0] mres_ff, mres_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [W-1:0] drive_ff, drive_in;

   logic signed [W:0]    err_wide;
   logic signed [W:0]    diff_wide;
   logic [W:0]           diff_neg;
   logic [W-1:0]         diff_mag;
   logic signed [W-1:0]  opa;
   logic signed [BW:0]   opb;
   logic [W-1:0]         opa_neg;
   logic [BW:0]          opb_neg;
   logic [W-1:0]         mag_a;
   logic [BW-1:0]        mag_b;
   logic [W+BW-1:0]      prod;
   logic signed [PW-1:0] prod_s;
   logic signed [PW-1:0] prod_signed;
   logic signed [W-1:0]  term;
   logic signed [PW:0]   isum;
   logic signed [PW:0]   lim_p;
   logic signed [PW:0]   lim_n;
   logic [W-1:0]         quot;
   logic                 quot_ovf;
   logic                 dsat;
   logic [W-1:0]         quot_neg;
   logic signed [W-1:0]  sum_sat;
   logic signed [W-1:0]  raised;

   always_comb begin
      gain_p_in   = gain_p_ff;
      gain_i_in   = gain_i_ff;
      gain_d_in   = gain_d_ff;
      out_low_in  = out_low_ff;
      out_high_in = out_high_ff;
      limit_in    = limit_ff;
      target_in   = target_ff;
      if (csr_we) begin
         unique case (csr_index)
            pid_pkg::CSR_GAIN_P:         gain_p_in   = csr_wdata;
            pid_pkg::CSR_GAIN_I:         gain_i_in   = csr_wdata;
            pid_pkg::CSR_GAIN_D:         gain_d_in   = csr_wdata;
            pid_pkg::CSR_OUTPUT_LOW:     out_low_in  = csr_wdata;
            pid_pkg::CSR_OUTPUT_HIGH:    out_high_in = csr_wdata;
            pid_pkg::CSR_INTEGRAL_LIMIT: limit_in    = csr_wdata[W-2:0];
            pid_pkg::CSR_TARGET:         target_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      meas_in = meas_ff;
      dt_in   = dt_ff;
      if (cmd.load_in) begin
         meas_in = measured;
         dt_in   = (step_time == '0) ? S'(pid_pkg::ZERO_STEP_UNITS) : step_time;
      end

      err_wide = {target_ff[W-1], target_ff} - {meas_ff[W-1], meas_ff};
      err_in   = err_ff;
      if (cmd.calc_error) begin
         if (err_wide[W] != err_wide[W-1]) begin
            err_in = err_wide[W] ? VMIN_W : VMAX_W;
         end else begin
            err_in = err_wide[W-1:0];
         end
      end

      diff_wide = {err_ff[W-1], err_ff} - {last_err_ff[W-1], last_err_ff};
      diff_neg  = -diff_wide;
      diff_mag  = diff_wide[W] ? diff_neg[W-1:0] : diff_wide[W-1:0];
      dneg_in   = cmd.start_div ? diff_wide[W] : dneg_ff;

      last_err_in = last_err_ff;
      if (cmd.clear_state) begin
         last_err_in = '0;
      end else if (cmd.save_error) begin
         last_err_in = err_ff;
      end
   end

   always_comb begin
      case (cmd.mul_op)
         pid_pkg::MUL_INC: begin
            opa = err_ff;
            opb = {{(BW+1-S){1'b0}}, dt_ff};
         end
         pid_pkg::MUL_P: begin
            opa = gain_p_ff;
            opb = {{(BW+1-W){err_ff[W-1]}}, err_ff};
         end
         pid_pkg::MUL_I: begin
            opa = gain_i_ff;
            opb = {{(BW+1-W){integ_ff[W-1]}}, integ_ff};
         end
         default: begin
            opa = gain_d_ff;
            opb = {{(BW+1-W){deriv_ff[W-1]}}, deriv_ff};
         end
      endcase
      opa_neg = -opa;
      opb_neg = -opb;
      mag_a   = opa[W-1] ? opa_neg : opa;
      mag_b   = opb[BW] ? opb_neg[BW-1:0] : opb[BW-1:0];
      mneg_in = cmd.mul_start ? (opa[W-1] ^ opb[BW]) : mneg_ff;
      mop_in  = cmd.mul_start ? cmd.mul_op : mop_ff;

      prod_s      = {1'b0, prod};
      prod_signed = mneg_ff ? -prod_s : prod_s;
      mres_in     = mres_ff;
      if (cmd.mul_fix) begin
         mres_in = (mop_ff == pid_pkg::MUL_INC) ? (prod_signed >>> TF) : (prod_signed >>> FB);
      end
   end

   always_comb begin
      isum  = {mres_ff[PW-1], mres_ff} + {{(PW+1-W){integ_ff[W-1]}}, integ_ff};
      lim_p = {{(PW+2-W){1'b0}}, limit_ff};
      lim_n = -lim_p;
      integ_in = integ_ff;
      if (cmd.clear_state) begin
         integ_in = '0;
      end else if (cmd.integ_update) begin
         if (isum < lim_n) begin
            integ_in = lim_n[W-1:0];
         end else if (isum > lim_p) begin
            integ_in = lim_p[W-1:0];
         end else begin
            integ_in = isum[W-1:0];
         end
      end

      if (mres_ff > MAX_P) begin
         term = VMAX_W;
      end else if (mres_ff < MIN_P) begin
         term = VMIN_W;
      end else begin
         term = mres_ff[W-1:0];
      end
      sum_in = sum_ff;
      if (cmd.sum_clear) begin
         sum_in = '0;
      end else if (cmd.sum_add) begin
         sum_in = sum_ff + {{2{term[W-1]}}, term};
      end

      dsat     = quot_ovf | quot[W-1];
      quot_neg = -quot;
      deriv_in = deriv_ff;
      if (cmd.deriv_load) begin
         if (dneg_ff) begin
            deriv_in = dsat ? VMIN_W : quot_neg;
         end else begin
            deriv_in = dsat ? VMAX_W : quot;
         end
      end

      if (sum_ff > MAX_S) begin
         sum_sat = VMAX_W;
      end else if (sum_ff < MIN_S) begin
         sum_sat = VMIN_W;
      end else begin
         sum_sat = sum_ff[W-1:0];
      end
      raised   = (sum_sat < out_low_ff) ? out_low_ff : sum_sat;
      drive_in = cmd.out_load ? ((raised > out_high_ff) ? out_high_ff : raised) : drive_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= W'(pid_pkg::GAIN_P_RESET);
         gain_i_ff   <= W'(pid_pkg::GAIN_I_RESET);
         gain_d_ff   <= W'(pid_pkg::GAIN_D_RESET);
         out_low_ff  <= W'(LOW_L);
         out_high_ff <= W'(HIGH_L);
         limit_ff    <= (W-1)'(LIM_L);
         target_ff   <= W'(pid_pkg::TARGET_RESET);
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else begin
         gain_p_ff   <= gain_p_in;
         gain_i_ff   <= gain_i_in;
         gain_d_ff   <= gain_d_in;
         out_low_ff  <= out_low_in;
         out_high_ff <= out_high_in;
         limit_ff    <= limit_in;
         target_ff   <= target_in;
         integ_ff    <= integ_in;
         last_err_ff <= last_err_in;
      end
      meas_ff  <= meas_in;
      dt_ff    <= dt_in;
      err_ff   <= err_in;
      deriv_ff <= deriv_in;
      dneg_ff  <= dneg_in;
      mneg_ff  <= mneg_in;
      mop_ff   <= mop_in;
      mres_ff  <= mres_in;
      sum_ff   <= sum_in;
      drive_ff <= drive_in;
   end

   pid_mul #(
      .AW (W),
      .BW (BW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .mcand   (mag_a),
      .mplier  (mag_b),
      .busy    (stat.mul_busy),
      .product (prod)
   );

   pid_div #(
      .VALUE_WIDTH (W),
      .STEP_WIDTH  (S)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (diff_mag),
      .divisor  (dt_ff),
      .busy     (stat.div_busy),
      .quotient (quot),
      .overflow (quot_ovf)
   );

   assign drive = drive_ff;

endmodule

// ===== hdl/pid_ctrl.sv =====
// ----------------------------------------------------------------------------
// PID controller sequencer
// State machine that handles both handshakes and steps the datapath through
// error, integral, derivative and the three gain products.
// ----------------------------------------------------------------------------
module pid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pid_pkg::cmd_type  cmd,
   input  pid_pkg::stat_type stat
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_ERROR   = 4'd1;
   localparam logic [3:0] ST_START   = 4'd2;
   localparam logic [3:0] ST_INC_RUN = 4'd3;
   localparam logic [3:0] ST_INC_ADD = 4'd4;
   localparam logic [3:0] ST_P_RUN   = 4'd5;
   localparam logic [3:0] ST_P_ADD   = 4'd6;
   localparam logic [3:0] ST_I_RUN   = 4'd7;
   localparam logic [3:0] ST_I_ADD   = 4'd8;
   localparam logic [3:0] ST_D_WAIT  = 4'd9;
   localparam logic [3:0] ST_D_START = 4'd10;
   localparam logic [3:0] ST_D_RUN   = 4'd11;
   localparam logic [3:0] ST_D_ADD   = 4'd12;
   localparam logic [3:0] ST_DONE    = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_stall = reset | (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_in = 1'b1;
               if (req_func == pid_pkg::FUNC_CLEAR) begin
                  cmd.clear_state = 1'b1;
               end else begin
                  state_in = ST_ERROR;
               end
            end
         end
         ST_ERROR: begin
            cmd.calc_error = 1'b1;
            state_in       = ST_START;
         end
         ST_START: begin
            cmd.start_div  = 1'b1;
            cmd.save_error = 1'b1;
            cmd.mul_start  = 1'b1;
            cmd.mul_op     = pid_pkg::MUL_INC;
            state_in       = ST_INC_RUN;
         end
         ST_INC_RUN: begin
            if (!stat.mul_busy) begin
               cmd.mul_fix = 1'b1;
               state_in    = ST_INC_ADD;
            end
         end
         ST_INC_ADD: begin
            cmd.integ_update = 1'b1;
            cmd.sum_clear    = 1'b1;
            cmd.mul_start    = 1'b1;
            cmd.mul_op       = pid_pkg::MUL_P;
            state_in         = ST_P_RUN;
         end
         ST_P_RUN: begin
            if (!stat.mul_busy) begin
               cmd.mul_fix = 1'b1;
               state_in    = ST_P_ADD;
            end
         end
         ST_P_ADD: begin
            cmd.sum_add   = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_op    = pid_pkg::MUL_I;
            state_in      = ST_I_RUN;
         end
         ST_I_RUN: begin
            if (!stat.mul_busy) begin
               cmd.mul_fix = 1'b1;
               state_in    = ST_I_ADD;
            end
         end
         ST_I_ADD: begin
            cmd.sum_add = 1'b1;
            state_in    = ST_D_WAIT;
         end
         ST_D_WAIT: begin
            if (!stat.div_busy) begin
               cmd.deriv_load = 1'b1;
               state_in       = ST_D_START;
            end
         end
         ST_D_START: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = pid_pkg::MUL_D;
            state_in      = ST_D_RUN;
         end
         ST_D_RUN: begin
            if (!stat.mul_busy) begin
               cmd.mul_fix = 1'b1;
               state_in    = ST_D_ADD;
            end
         end
         ST_D_ADD: begin
            cmd.sum_add = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/pid_controller_step.sv =====
// ----------------------------------------------------------------------------
// PID controller step
// Discrete PID update in signed Q16.16 with integral anti-windup and
// clamped output, built from a sequencer and a multi-cycle datapath.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_func, req_measured,
//                                             req_step_time
//   rsp      out        rsp_valid/rsp_stall   rsp_drive
//   csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// An update waits on the one-bit-per-cycle divider that forms the derivative.
// A clear gives no result. Reset restores the register defaults and zeroes
// the integral and the previous error. A result that waits under rsp_stall
// sits in the output register while the next transfer is taken.
// ----------------------------------------------------------------------------
module pid_controller_step #(
   parameter int VALUE_WIDTH = 32,
   parameter int STEP_WIDTH  = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic signed [VALUE_WIDTH-1:0]       req_measured,
   input  logic [STEP_WIDTH-1:0]               req_step_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]       rsp_drive,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pid_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [VALUE_WIDTH-1:0]              csr_wdata
);

   pid_pkg::cmd_type  cmd;
   pid_pkg::stat_type stat;
   logic              csr_we;

   assign csr_ready = ~reset;
   assign csr_we    = csr_valid & csr_ready;

   pid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   pid_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .STEP_WIDTH  (STEP_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .measured  (req_measured),
      .step_time (req_step_time),
      .drive     (rsp_drive)
   );

endmodule
